### sv/pbfd_pkg.sv
package pbfd_pkg;

    // Default table depth
    localparam int PORTS_PER_TABLE_DEF = 8;

    // Frame header constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [5:0]  TCP_HDR_BYTES = 6'd20;
    localparam logic [5:0]  UDP_HDR_BYTES = 6'd8;

    // Request codes
    localparam logic [1:0] REQ_CLASSIFY = 2'd0;
    localparam logic [1:0] REQ_ADD      = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    // Table selectors
    localparam logic [1:0] TBL_TCP_DST = 2'd0;
    localparam logic [1:0] TBL_TCP_SRC = 2'd1;
    localparam logic [1:0] TBL_UDP_DST = 2'd2;
    localparam logic [1:0] TBL_UDP_SRC = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ALREADY = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_OWN_MAC    = 1'b0;
    localparam logic CFG_PROTO_MASK = 1'b1;

    // Port widths
    localparam int IN_W   = 144;
    localparam int IN_U_W = 4;
    localparam int OUT_W  = 56;
    localparam int MAC_W  = 48;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic scan_en;
        logic commit;
    } pbfd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic cnt_last;
        logic out_stall;
    } pbfd_sts_t;

endpackage

### sv/port_based_frame_divert_classifier_unit.sv
// Channel   Dir  Fields (tdata/tuser from bit 0 up)
// s_*       in   tuser: req_type[1:0] table_sel[3:2]
//                tdata: port_value, dest_mac, ether_type, ip_header_words,
//                       ip_protocol, src_port, dst_port, data_len
// m_*       out  tdata: status, divert, malformed, new_dest_mac
// cfg_*     in   index 0 own_mac, index 1 proto_mask
//
// One request at a time. A request that scans a table (add or remove of a
// nonzero port, or a classify that needs a port lookup) walks the table
// memory one slot per cycle through its registered read, folds in the last
// read data in a drain state and then commits its result. Other requests go
// from the check state straight to the commit.
// Reset (aresetn low, synchronous) empties all tables at once through the
// per-slot valid bits and clears the config registers; no clearing pass.
// A held result stalls only the final commit; s_tready returns after it.
module port_based_frame_divert_classifier_unit #(
    parameter int PORTS_PER_TABLE = pbfd_pkg::PORTS_PER_TABLE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // port_value[15:0] dest_mac[63:16] ether_type[79:64] ip_header_words[83:80]
    // ip_protocol[91:84] src_port[107:92] dst_port[123:108] data_len[139:124]
    input  logic [pbfd_pkg::IN_W-1:0]   s_tdata,
    // req_type[1:0] table_sel[3:2]
    input  logic [pbfd_pkg::IN_U_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[1:0] divert[2] malformed[3] new_dest_mac[51:4]
    output logic [pbfd_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [pbfd_pkg::MAC_W-1:0]  cfg_wdata
);
    import pbfd_pkg::*;

    pbfd_cmd_t cmd;
    pbfd_sts_t sts;

    // sequencer: accept, check, scan, drain, commit
    pbfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, header checks, output register
    pbfd_datapath #(
        .PORTS_PER_TABLE (PORTS_PER_TABLE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### sv/pbfd_ctrl.sv
module pbfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pbfd_pkg::pbfd_sts_t sts,
    output pbfd_pkg::pbfd_cmd_t cmd
);
    import pbfd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.scan_en = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.cnt_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read data is folded in this cycle
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/pbfd_datapath.sv
module pbfd_datapath #(
    parameter int PORTS_PER_TABLE = pbfd_pkg::PORTS_PER_TABLE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [pbfd_pkg::IN_W-1:0]   s_tdata,
    input  logic [pbfd_pkg::IN_U_W-1:0] s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pbfd_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [pbfd_pkg::MAC_W-1:0]  cfg_wdata,
    input  pbfd_pkg::pbfd_cmd_t         cmd,
    output pbfd_pkg::pbfd_sts_t         sts
);
    import pbfd_pkg::*;

    localparam int NE = 4 * PORTS_PER_TABLE;
    localparam int AW = $clog2(NE);
    localparam int IW = (PORTS_PER_TABLE > 1) ? $clog2(PORTS_PER_TABLE) : 1;

    // config registers
    logic [MAC_W-1:0] own_mac_reg;
    logic [3:0]       proto_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg    <= '0;
            proto_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_MAC:    own_mac_reg    <= cfg_wdata;
                CFG_PROTO_MASK: proto_mask_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // latched request
    logic [1:0]  req_reg, sel_reg;
    logic [15:0] pval_reg, etype_reg, sport_reg, dport_reg, dlen_reg;
    logic [47:0] dmac_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  proto_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg   <= s_tuser[1:0];
            sel_reg   <= s_tuser[3:2];
            pval_reg  <= s_tdata[15:0];
            dmac_reg  <= s_tdata[63:16];
            etype_reg <= s_tdata[79:64];
            ihl_reg   <= s_tdata[83:80];
            proto_reg <= s_tdata[91:84];
            sport_reg <= s_tdata[107:92];
            dport_reg <= s_tdata[123:108];
            dlen_reg  <= s_tdata[139:124];
        end
    end

    // classify decision ahead of any table lookup
    logic [5:0] ihl_bytes;
    logic       ip_short, tcp_short, udp_short;
    logic       cls_div, cls_bad, cls_lookup, cls_udp;

    assign ihl_bytes = {ihl_reg, 2'b00};
    assign ip_short  = 17'(ihl_bytes) >= 17'(dlen_reg);
    assign tcp_short = (17'(ihl_bytes) + 17'(TCP_HDR_BYTES)) >= 17'(dlen_reg);
    assign udp_short = (17'(ihl_bytes) + 17'(UDP_HDR_BYTES)) >= 17'(dlen_reg);
    assign cls_udp   = (proto_reg == IP_PROTO_UDP);

    always_comb begin
        cls_div    = 1'b0;
        cls_bad    = 1'b0;
        cls_lookup = 1'b0;
        if (dmac_reg != own_mac_reg && etype_reg == ETHERTYPE_IPV4) begin
            if (proto_mask_reg[0]) begin
                cls_div = 1'b1;
            end else if (ip_short) begin
                cls_bad = 1'b1;
            end else if (proto_reg == IP_PROTO_ICMP) begin
                cls_div = proto_mask_reg[3];
            end else if (proto_reg == IP_PROTO_TCP) begin
                if (proto_mask_reg[1]) cls_div = 1'b1;
                else if (tcp_short)    cls_bad = 1'b1;
                else                   cls_lookup = 1'b1;
            end else if (cls_udp) begin
                if (proto_mask_reg[2]) cls_div = 1'b1;
                else if (udp_short)    cls_bad = 1'b1;
                else                   cls_lookup = 1'b1;
            end
        end
    end

    assign sts.need_scan = (req_reg == REQ_ADD || req_reg == REQ_REMOVE) ? (pval_reg != 16'd0)
                         : (req_reg == REQ_CLASSIFY) && cls_lookup;

    // slot counter
    logic [IW-1:0] cnt_reg, idx_d_reg;
    logic          acc_vld_reg;

    assign sts.cnt_last = (cnt_reg == IW'(PORTS_PER_TABLE - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cnt_reg <= '0;
        end else if (cmd.scan_en) begin
            cnt_reg <= cnt_reg + IW'(1);
        end
        if (cmd.scan_en) begin
            idx_d_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= 1'b0;
        end else begin
            acc_vld_reg <= cmd.scan_en;
        end
    end

    // table memory, two read ports; valid bits stand for the empty state
    logic [1:0]    tbl_a, tbl_b;
    logic [AW-1:0] addr_a, addr_b, waddr;
    logic [15:0]   mem [NE];
    logic [NE-1:0] valid_reg;
    logic [15:0]   rd_a_reg, rd_b_reg;
    logic          rv_a_reg, rv_b_reg;

    assign tbl_a  = (req_reg == REQ_CLASSIFY) ? (cls_udp ? TBL_UDP_DST : TBL_TCP_DST) : sel_reg;
    assign tbl_b  = cls_udp ? TBL_UDP_SRC : TBL_TCP_SRC;
    assign addr_a = AW'(AW'(tbl_a) * AW'(PORTS_PER_TABLE)) + AW'(cnt_reg);
    assign addr_b = AW'(AW'(tbl_b) * AW'(PORTS_PER_TABLE)) + AW'(cnt_reg);

    // accumulators
    logic          match_reg, free_reg, hit_reg;
    logic [IW-1:0] match_idx_reg, free_idx_reg;
    logic [15:0]   va, vb;

    assign va = rv_a_reg ? rd_a_reg : 16'd0;
    assign vb = rv_b_reg ? rd_b_reg : 16'd0;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else if (acc_vld_reg) begin
            if (!match_reg && va == pval_reg) begin
                match_reg     <= 1'b1;
                match_idx_reg <= idx_d_reg;
            end
            if (!free_reg && va == 16'd0) begin
                free_reg     <= 1'b1;
                free_idx_reg <= idx_d_reg;
            end
            if ((va != 16'd0 && va == dport_reg) || (vb != 16'd0 && vb == sport_reg)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // commit
    logic        add_wr, rem_wr;
    logic [1:0]  res_status;
    logic        res_div, res_bad;
    logic [47:0] res_mac;

    assign add_wr = cmd.commit && req_reg == REQ_ADD && pval_reg != 16'd0
                    && !match_reg && free_reg;
    assign rem_wr = cmd.commit && req_reg == REQ_REMOVE && pval_reg != 16'd0 && match_reg;
    assign waddr  = AW'(AW'(sel_reg) * AW'(PORTS_PER_TABLE))
                    + AW'(add_wr ? free_idx_reg : match_idx_reg);

    always_ff @(posedge aclk) begin
        if (add_wr) begin
            mem[waddr] <= pval_reg;
        end
        if (cmd.scan_en) begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
            rv_a_reg <= valid_reg[addr_a];
            rv_b_reg <= valid_reg[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.commit && req_reg == REQ_CLEAR) begin
            valid_reg <= '0;
        end else if (add_wr) begin
            valid_reg[waddr] <= 1'b1;
        end else if (rem_wr) begin
            valid_reg[waddr] <= 1'b0;
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_div    = 1'b0;
        res_bad    = 1'b0;
        res_mac    = '0;
        case (req_reg)
            REQ_ADD: begin
                if (pval_reg == 16'd0) res_status = ST_INVALID;
                else if (match_reg)    res_status = ST_ALREADY;
                else if (free_reg)     res_status = ST_OK;
                else                   res_status = ST_FULL;
            end
            REQ_REMOVE: begin
                res_status = (pval_reg != 16'd0 && match_reg) ? ST_OK : ST_INVALID;
            end
            REQ_CLEAR: begin
                res_status = ST_OK;
            end
            default: begin
                res_div = cls_lookup ? hit_reg : cls_div;
                res_bad = cls_bad;
                res_mac = res_div ? own_mac_reg : dmac_reg;
            end
        endcase
    end

    // output register
    logic               out_vld_reg;
    logic [OUT_W-1:0]   out_data_reg;

    assign sts.out_stall = out_vld_reg && !m_tready;
    assign m_tvalid      = out_vld_reg;
    assign m_tdata       = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {4'b0, res_mac, res_bad, res_div, res_status};
        end
    end

endmodule

### sv/pbfd_checker.sv
module pbfd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pbfd_pkg::OUT_W-1:0] m_tdata
);
    import pbfd_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // a frame is never both diverted and malformed
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("divert and malformed both set");

    // flagged frames carry ok status
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2] || m_tdata[3]) |-> m_tdata[1:0] == ST_OK)
        else $error("classify result with bad status");

endmodule

bind port_based_frame_divert_classifier_unit pbfd_checker u_pbfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/tb_port_based_frame_divert_classifier_unit.sv
`timescale 1ns / 100ps

module tb_port_based_frame_divert_classifier_unit;
    import pbfd_pkg::*;

    localparam int PPT = PORTS_PER_TABLE_DEF;

    // One request as it travels on s_tuser / s_tdata
    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  sel;
        logic [15:0] port;
        logic [47:0] dmac;
        logic [15:0] etype;
        logic [3:0]  ihw;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] dlen;
    } divert_req_t;

    // One verdict as it comes back on m_tdata
    typedef struct {
        logic [1:0]  status;
        logic        divert;
        logic        malformed;
        logic [47:0] mac;
    } divert_res_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [IN_U_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_index = 1'b0;
    logic [MAC_W-1:0]    cfg_wdata = '0;

    // Shadow of the block: port tables and the two registers
    logic [15:0] port_tbl [0:3][0:PPT-1];
    logic [47:0] own_mac_m;
    logic [3:0]  proto_mask_m;

    divert_res_t expected_verdicts [$];
    logic [15:0] port_pool [0:11];

    int mismatches     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;   // set by a test, consumed by the sink process
    int hold_left      = 0;

    port_based_frame_divert_classifier_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // port_value, dest_mac, ether_type, ip_header_words,
                                // ip_protocol, src_port, dst_port, data_len
        .s_tuser   (s_tuser),   // req_type, table_sel
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // status, divert, malformed, new_dest_mac
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        foreach (port_tbl[t, i]) port_tbl[t][i] = '0;
        own_mac_m    = '0;
        proto_mask_m = '0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------
    function automatic logic [1:0] tbl_add(input logic [1:0] t, input logic [15:0] p);
        if (p == 16'd0) return ST_INVALID;
        for (int i = 0; i < PPT; i++)
            if (port_tbl[t][i] == p) return ST_ALREADY;
        for (int i = 0; i < PPT; i++) begin
            if (port_tbl[t][i] == 16'd0) begin
                port_tbl[t][i] = p;
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    function automatic logic [1:0] tbl_remove(input logic [1:0] t, input logic [15:0] p);
        if (p == 16'd0) return ST_INVALID;
        for (int i = 0; i < PPT; i++) begin
            if (port_tbl[t][i] == p) begin
                port_tbl[t][i] = '0;
                return ST_OK;
            end
        end
        return ST_INVALID;
    endfunction

    // empty slots never match, even against port 0
    function automatic logic tbl_hit(input logic [1:0] dt, input logic [1:0] st,
                                     input logic [15:0] dport, input logic [15:0] sport);
        for (int i = 0; i < PPT; i++) begin
            if (port_tbl[dt][i] != 16'd0 && port_tbl[dt][i] == dport) return 1'b1;
            if (port_tbl[st][i] != 16'd0 && port_tbl[st][i] == sport) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic divert_res_t predict_divert(input divert_req_t r);
        divert_res_t v;
        int hdr;
        int dl;
        v.status    = ST_OK;
        v.divert    = 1'b0;
        v.malformed = 1'b0;
        v.mac       = '0;
        hdr = 4 * r.ihw;
        dl  = int'(r.dlen);
        case (r.kind)
            REQ_ADD:    v.status = tbl_add(r.sel, r.port);
            REQ_REMOVE: v.status = tbl_remove(r.sel, r.port);
            REQ_CLEAR:  foreach (port_tbl[t, i]) port_tbl[t][i] = '0;
            REQ_CLASSIFY: begin
                v.mac = r.dmac;
                // own traffic and non-IPv4 pass untouched
                if (r.dmac != own_mac_m && r.etype == ETHERTYPE_IPV4) begin
                    if (proto_mask_m[0]) begin
                        v.divert = 1'b1;
                    end else if (hdr >= dl) begin
                        v.malformed = 1'b1;
                    end else if (r.proto == IP_PROTO_ICMP) begin
                        v.divert = proto_mask_m[3];
                    end else if (r.proto == IP_PROTO_TCP) begin
                        if (proto_mask_m[1]) v.divert = 1'b1;
                        else if (hdr + TCP_HDR_BYTES >= dl) v.malformed = 1'b1;
                        else v.divert = tbl_hit(TBL_TCP_DST, TBL_TCP_SRC, r.dport, r.sport);
                    end else if (r.proto == IP_PROTO_UDP) begin
                        if (proto_mask_m[2]) v.divert = 1'b1;
                        else if (hdr + UDP_HDR_BYTES >= dl) v.malformed = 1'b1;
                        else v.divert = tbl_hit(TBL_UDP_DST, TBL_UDP_SRC, r.dport, r.sport);
                    end
                end
                if (v.divert) v.mac = own_mac_m;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------
    // Predict at the edge the request transfer happens
    always @(posedge aclk) begin : capture_requests
        divert_req_t r;
        if (aresetn && s_tvalid && s_tready) begin
            r.kind  = s_tuser[1:0];
            r.sel   = s_tuser[3:2];
            r.port  = s_tdata[15:0];
            r.dmac  = s_tdata[63:16];
            r.etype = s_tdata[79:64];
            r.ihw   = s_tdata[83:80];
            r.proto = s_tdata[91:84];
            r.sport = s_tdata[107:92];
            r.dport = s_tdata[123:108];
            r.dlen  = s_tdata[139:124];
            expected_verdicts.push_back(predict_divert(r));
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40)
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_verdicts
        divert_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
            end else begin
                e = expected_verdicts.pop_front();
                if (m_tdata[1:0] !== e.status)
                    report_mismatch("status", 64'(m_tdata[1:0]), 64'(e.status));
                if (m_tdata[2] !== e.divert)
                    report_mismatch("divert", 64'(m_tdata[2]), 64'(e.divert));
                if (m_tdata[3] !== e.malformed)
                    report_mismatch("malformed", 64'(m_tdata[3]), 64'(e.malformed));
                if (m_tdata[51:4] !== e.mac)
                    report_mismatch("new_dest_mac", 64'(m_tdata[51:4]), 64'(e.mac));
            end
        end
    end

    // Result side ready: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin : sink_ready
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Returns at the edge of the transfer; the next call moves on at the
    // following falling edge, so tvalid stays up between back-to-back items
    task automatic send_req(input divert_req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {r.sel, r.kind};
        s_tdata  <= {4'd0, r.dlen, r.dport, r.sport, r.proto, r.ihw, r.etype, r.dmac, r.port};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every outstanding verdict
    task automatic wait_for_verdicts(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Only called with the block idle
    task automatic write_cfg(input logic idx, input logic [47:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_OWN_MAC) own_mac_m = value;
        else proto_mask_m = value[3:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic divert_req_t table_req(input logic [1:0] kind, input logic [1:0] sel,
                                              input logic [15:0] port);
        divert_req_t r;
        r = '{kind: kind, sel: sel, port: port, default: '0};
        return r;
    endfunction

    function automatic divert_req_t frame_req(input logic [47:0] dmac, input logic [15:0] etype,
                                              input logic [3:0] ihw, input logic [7:0] proto,
                                              input logic [15:0] sport, input logic [15:0] dport,
                                              input logic [15:0] dlen);
        divert_req_t r;
        r = '{kind: REQ_CLASSIFY, dmac: dmac, etype: etype, ihw: ihw, proto: proto,
              sport: sport, dport: dport, dlen: dlen, default: '0};
        return r;
    endfunction

    // Random request: mostly plausible frames around the length limits
    // and table edits from a small port pool, some pure noise
    function automatic divert_req_t gen_item();
        divert_req_t r;
        int pick;
        int hdr;
        r.kind  = 2'($urandom);
        r.sel   = 2'($urandom);
        r.port  = 16'($urandom);
        r.dmac  = 48'({$urandom, $urandom});
        r.etype = 16'($urandom);
        r.ihw   = 4'($urandom);
        r.proto = 8'($urandom);
        r.sport = 16'($urandom);
        r.dport = 16'($urandom);
        r.dlen  = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 8) return r;
        if (pick < 38) begin
            pick = $urandom_range(99);
            r.kind = (pick < 1) ? REQ_CLEAR : (pick < 70) ? REQ_ADD : REQ_REMOVE;
            pick = $urandom_range(19);
            if (pick == 0) r.port = 16'd0;
            else if (pick > 1) r.port = port_pool[$urandom_range(11)];
            return r;
        end
        r.kind = REQ_CLASSIFY;
        if ($urandom_range(9) == 0) r.dmac = own_mac_m;
        if ($urandom_range(99) < 88) r.etype = ETHERTYPE_IPV4;
        if ($urandom_range(3) != 0) r.ihw = 4'd5;
        pick = $urandom_range(19);
        if (pick < 6) r.proto = IP_PROTO_TCP;
        else if (pick < 12) r.proto = IP_PROTO_UDP;
        else if (pick < 15) r.proto = IP_PROTO_ICMP;
        if ($urandom_range(9) < 7) r.sport = port_pool[$urandom_range(11)];
        if ($urandom_range(9) < 7) r.dport = port_pool[$urandom_range(11)];
        hdr = 4 * r.ihw;
        case ($urandom_range(5))
            0: r.dlen = 16'(hdr + $urandom_range(2) - 1);
            1: r.dlen = 16'(hdr + 7 + $urandom_range(2));
            2: r.dlen = 16'(hdr + 19 + $urandom_range(2));
            3, 4: r.dlen = 16'(hdr + 21 + $urandom_range(1500));
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Add/remove status codes, fill to full, duplicates, port zero
    task automatic test_table_ops();
        send_req(table_req(REQ_ADD, TBL_TCP_DST, 16'd0));
        send_req(table_req(REQ_ADD, TBL_TCP_DST, 16'hFFFF));
        send_req(table_req(REQ_ADD, TBL_TCP_DST, 16'hFFFF));
        for (int p = 1; p < PPT; p++) send_req(table_req(REQ_ADD, TBL_TCP_DST, 16'(p)));
        send_req(table_req(REQ_ADD, TBL_TCP_DST, 16'd100));
        send_req(table_req(REQ_REMOVE, TBL_TCP_DST, 16'd0));
        send_req(table_req(REQ_REMOVE, TBL_TCP_DST, 16'd100));
        send_req(table_req(REQ_REMOVE, TBL_TCP_DST, 16'd3));
        send_req(table_req(REQ_ADD, TBL_TCP_SRC, 16'd22));
        send_req(table_req(REQ_ADD, TBL_UDP_SRC, 16'd53));
        wait_for_verdicts(4);
    endtask

    // Each classify path; tables as left by test_table_ops
    task automatic test_classify();
        logic [47:0] own;
        own = 48'h0200_0000_0001;
        write_cfg(CFG_OWN_MAC, own);
        write_cfg(CFG_PROTO_MASK, 48'd0);
        send_req(frame_req(own, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd0, 16'hFFFF, 16'd100));
        send_req(frame_req(48'h0A0B_0C0D_0E0F, 16'h86DD, 4'd5, IP_PROTO_TCP, 16'd0, 16'hFFFF,
                           16'd100));
        send_req(frame_req(48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd0,
                           16'hFFFF, 16'hFFFF));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd22, 16'd9, 16'd41));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd21, 16'd3, 16'd41));
        // TCP header exactly reaching the data length
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd0, 16'hFFFF, 16'd40));
        // IP header reaching the data length
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'hF, IP_PROTO_TCP, 16'd0, 16'hFFFF, 16'd60));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'd53, 16'd0, 16'd28));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'd53, 16'd0, 16'd29));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_ICMP, 16'd0, 16'd0, 16'd84));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, 8'hFF, 16'd22, 16'hFFFF, 16'd100));
        wait_for_verdicts(4);
        // TCP + ICMP divert-all; upper data bits must be dropped
        write_cfg(CFG_PROTO_MASK, 48'hFFFF_FFFF_FFFA);
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_ICMP, 16'd0, 16'd0, 16'd84));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd0, 16'd0, 16'd30));
        wait_for_verdicts(4);
        // all-IP wins even over a zero-length header check
        write_cfg(CFG_PROTO_MASK, 48'h1);
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd0, 8'd0, 16'd0, 16'd0, 16'd0));
        wait_for_verdicts(4);
        write_cfg(CFG_PROTO_MASK, 48'h4);
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_UDP, 16'd0, 16'd0, 16'd21));
        wait_for_verdicts(4);
        write_cfg(CFG_PROTO_MASK, 48'h0);
        send_req(table_req(REQ_CLEAR, TBL_TCP_DST, 16'd0));
        send_req(frame_req(48'd0, ETHERTYPE_IPV4, 4'd5, IP_PROTO_TCP, 16'd0, 16'hFFFF, 16'd100));
        wait_for_verdicts(4);
    endtask

    // Four idle patterns, two register settings each
    task automatic test_random_traffic();
        int src_pct [0:3];
        int sink_pct [0:3];
        logic [3:0] masks [0:7];
        logic [47:0] mac;
        int k;
        src_pct  = '{0, 50, 0, 21};
        sink_pct = '{0, 0, 50, 21};
        masks    = '{4'h0, 4'h0, 4'hF, 4'h1, 4'h2, 4'h4, 4'h8, 4'h0};
        foreach (port_pool[i]) port_pool[i] = 16'($urandom);
        port_pool[0] = 16'd1;
        port_pool[1] = 16'hFFFF;
        port_pool[2] = 16'd80;
        for (int ph = 0; ph < 4; ph++) begin
            for (int b = 0; b < 2; b++) begin
                k = 2 * ph + b;
                wait_for_verdicts(4);
                if (k == 0) mac = 48'd0;
                else if (k == 1) mac = 48'hFFFF_FFFF_FFFF;
                else mac = 48'({$urandom, $urandom});
                write_cfg(CFG_OWN_MAC, mac);
                write_cfg(CFG_PROTO_MASK, {44'($urandom), masks[k]});
                src_idle_pct   = src_pct[ph];
                sink_stall_pct = sink_pct[ph];
                repeat (150) send_req(gen_item());
            end
        end
        wait_for_verdicts(4);
    endtask

    // Long result hold-off with requests queued, then bursts with full drains
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_cfg(CFG_PROTO_MASK, 48'd0);
        hold_request = 300;
        repeat (40) send_req(gen_item());
        wait_for_verdicts(4);
        repeat (3) begin
            repeat (4) send_req(gen_item());
            wait_for_verdicts(1);
        end
    endtask

    initial begin : run_tests
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_table_ops();
        test_classify();
        test_random_traffic();
        test_backpressure();
        wait_for_verdicts(PPT + 8);
        if (expected_verdicts.size() != 0)
            report_mismatch("results missing", 64'(expected_verdicts.size()), 64'd0);
        if (mismatches == 0) begin
            $display("tb_port_based_frame_divert_classifier_unit OK");
        end else begin
            $display("tb_port_based_frame_divert_classifier_unit NOT OK");
        end
        $finish;
    end

    // Normal run finishes well before this watchdog fires
    initial begin : watchdog
        #5_000_000;
        $display("tb_port_based_frame_divert_classifier_unit NOT OK");
        $finish;
    end

endmodule
